>>> rtl/core/ttbeep_pkg.sv
// Shared types, constants and sine table generator for the two-tone beep block.
package ttbeep_pkg;

    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_PHASE_BITS       = 32;

    localparam int STEP_W   = 30;   // tone_step width
    localparam int LEN_W    = 16;   // note_length / sample index width
    localparam int SAMPLE_W = 16;
    localparam int MIX_W    = 20;   // 7*s1 + 3*s2, signed
    localparam int EN_W     = 19;   // envelope numerator, also |mix|
    localparam int DEN_W    = 22;   // 20 * envelope denominator
    localparam int NUM_W    = 2 * EN_W;
    localparam int Q_W      = 15;   // quotient magnitude never exceeds 16383

    localparam logic [STEP_W-1:0] TONE_STEP_RST   = 30'd42852281;
    localparam logic [LEN_W-1:0]  NOTE_LENGTH_RST = 16'd4410;

    localparam logic [0:0] CFG_TONE_STEP   = 1'b0;
    localparam logic [0:0] CFG_NOTE_LENGTH = 1'b1;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX1,
        S_IDX2,
        S_ROM2,
        S_MIX,
        S_MUL,
        S_DIV,
        S_OUT
    } seq_state_t;

    // Sine at a Q30 angle in [0, 2pi), amplitude 32767, degree-11 Taylor in Horner form.
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input logic [63:0] angle);
        logic [63:0] x;
        logic [63:0] r2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        logic        neg;
        x   = angle;
        neg = 1'b0;
        if (x >= Q30_PI)
        begin
            x   = x - Q30_PI;
            neg = 1'b1;
        end
        if (x > Q30_HALF_PI)
            x = Q30_PI - x;
        r2  = (x * x) >> 30;
        t   = Q30_ONE - r2 / 110;
        t   = Q30_ONE - ((r2 * t) >> 30) / 72;
        t   = Q30_ONE - ((r2 * t) >> 30) / 42;
        t   = Q30_ONE - ((r2 * t) >> 30) / 20;
        t   = Q30_ONE - ((r2 * t) >> 30) / 6;
        s   = (x * t) >> 30;
        mag = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return neg ? -$signed(mag[SAMPLE_W-1:0]) : $signed(mag[SAMPLE_W-1:0]);
    endfunction

endpackage

>>> rtl/core/two_tone_beep_with_envelope.sv
// Top level: two-tone beep generator with attack/sustain/decay envelope.
//
// Usage
//   Input channel (in_valid / in_stall, payload restart): one item per audio
//   sample tick. restart = 1 begins a new note at sample zero.
//   Output channel (out_valid / out_stall): one item per input item carrying
//   sample (signed 16-bit PCM), note_done (last sample of the note) and active.
//   Configuration (cfg_we / cfg_index / cfg_data): index 0 tone_step, index 1
//   note_length; write only while no item is in flight.
// Timing
//   A sounding tick, once accepted, passes in order: two ROM address multiplies
//   on the shared multiplier, two mix steps (the ROM reads overlap the second
//   multiply and the first mix step), one envelope multiply, a restoring
//   divider giving one quotient bit per cycle, and the result register write.
//   in_stall is high until that write, so no new item is taken while one is
//   in flight. A silent tick goes straight from acceptance to the write.
// Reset and stall
//   Reset loads the register defaults and leaves the block idle, silent.
//   The result register holds its item while out_stall is high; a new item may
//   be accepted meanwhile, but the sequencer waits before overwriting it.
module two_tone_beep_with_envelope
    import ttbeep_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = DEF_PHASE_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [STEP_W-1:0]          cfg_data,
    // input items
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       restart,
    // result items
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       note_done,
    output logic                       active
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int MA = (PHASE_BITS > EN_W) ? PHASE_BITS : EN_W;
    localparam int PW = MA + EN_W;
    localparam int CW = $clog2(Q_W);

    // ---------------------------------------------------------------
    // Sine ROM, built at elaboration, read with a registered output
    // ---------------------------------------------------------------
    typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            x    = (64'(k) * Q30_TWO_PI) / SINE_TABLE_DEPTH;
            r[k] = sine_entry(x);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    seq_state_t state_reg, state_next;

    logic [STEP_W-1:0]          tone_step_reg;
    logic [LEN_W-1:0]           note_length_reg;
    logic [LEN_W-1:0]           sample_index_reg;
    logic [PHASE_BITS-1:0]      phase_main_reg;
    logic [PHASE_BITS-1:0]      phase_fifth_reg;
    logic                       sounding_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       out_valid_reg;

    logic                       act_reg;      // this tick sounds
    logic                       done_reg;     // this tick is the last of the note
    logic [EN_W-1:0]            en_reg;
    logic [NUM_W-1:0]           dsh_reg;      // shifted divisor
    logic [PW-1:0]              prod_reg;     // product, then division remainder
    logic signed [SAMPLE_W-1:0] rom_q_reg;
    logic signed [MIX_W-1:0]    mix_reg;
    logic                       neg_reg;
    logic [Q_W-1:0]             q_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       note_done_reg;
    logic                       active_reg;

    // ---------------------------------------------------------------
    // Tick decode at acceptance: restart, note end, envelope
    // ---------------------------------------------------------------
    logic             accept;
    logic             can_write;
    logic [LEN_W-1:0] i_eff;
    logic             snd_eff;
    logic [19:0]      ten_i;
    logic [19:0]      six_n;
    logic [LEN_W-1:0] rest;
    logic [DEN_W-1:0] twenty_n;
    logic [EN_W-1:0]  en_new;
    logic [DEN_W-1:0] den_new;

    assign accept    = in_valid && !in_stall;
    assign can_write = !out_valid_reg || !out_stall;

    always_comb
    begin
        i_eff = restart ? '0 : sample_index_reg;
        if (restart)
            snd_eff = (note_length_reg != '0);
        else
            snd_eff = sounding_reg;
        // length lowered to or below the index ends the note silently
        if (snd_eff && (i_eff >= note_length_reg))
            snd_eff = 1'b0;

        ten_i    = (20'(i_eff) << 3) + (20'(i_eff) << 1);
        six_n    = (20'(note_length_reg) << 2) + (20'(note_length_reg) << 1);
        rest     = note_length_reg - i_eff;
        twenty_n = (DEN_W'(note_length_reg) << 4) + (DEN_W'(note_length_reg) << 2);

        priority if (ten_i < 20'(note_length_reg))
        begin
            en_new  = EN_W'(ten_i);                           // attack
            den_new = twenty_n;
        end
        else if (ten_i < six_n)
        begin
            en_new  = EN_W'(1);                               // sustain
            den_new = DEN_W'(20);
        end
        else
        begin
            en_new  = (EN_W'(rest) << 2) + EN_W'(rest);       // decay
            den_new = twenty_n << 1;
        end
    end

    // ---------------------------------------------------------------
    // Shared multiplier and restoring divide step
    // ---------------------------------------------------------------
    logic [MA-1:0]           mul_a;
    logic [EN_W-1:0]         mul_b;
    logic [PW-1:0]           mul_p;
    logic [EN_W-1:0]         mix_mag;
    logic [AW-1:0]           rom_addr;
    logic signed [MIX_W-1:0] s_ext;
    logic                    div_ge;
    logic [NUM_W-1:0]        div_rem;
    logic signed [SAMPLE_W-1:0] q_signed;

    assign mix_mag  = EN_W'(mix_reg[MIX_W-1] ? -mix_reg : mix_reg);
    assign mul_p    = PW'(mul_a) * PW'(mul_b);
    assign rom_addr = prod_reg[PHASE_BITS +: AW];
    assign s_ext    = MIX_W'(rom_q_reg);
    assign div_ge   = prod_reg[NUM_W-1:0] >= dsh_reg;
    assign div_rem  = prod_reg[NUM_W-1:0] - dsh_reg;
    assign q_signed = SAMPLE_W'(q_reg);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = snd_eff ? S_IDX1 : S_OUT;
            end
            S_IDX1: state_next = S_IDX2;
            S_IDX2: state_next = S_ROM2;
            S_ROM2: state_next = S_MIX;
            S_MIX:  state_next = S_MUL;
            S_MUL:  state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CW'(Q_W - 1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (can_write)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // operand selection for the shared multiplier, input handshake
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            S_IDX1:
            begin
                mul_a = MA'(phase_main_reg);
                mul_b = EN_W'(SINE_TABLE_DEPTH);
            end
            S_IDX2:
            begin
                mul_a = MA'(phase_fifth_reg);
                mul_b = EN_W'(SINE_TABLE_DEPTH);
            end
            S_MUL:
            begin
                mul_a = MA'(mix_mag);
                mul_b = en_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [STEP_W:0] step_fifth;
    assign step_fifth = {1'b0, tone_step_reg} + {2'b00, tone_step_reg[STEP_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tone_step_reg    <= TONE_STEP_RST;
            note_length_reg  <= NOTE_LENGTH_RST;
            sample_index_reg <= '0;
            phase_main_reg   <= '0;
            phase_fifth_reg  <= '0;
            sounding_reg     <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TONE_STEP:   tone_step_reg   <= cfg_data;
                    CFG_NOTE_LENGTH: note_length_reg <= cfg_data[LEN_W-1:0];
                    default:         tone_step_reg   <= tone_step_reg;
                endcase
            end

            if (accept)
            begin
                sounding_reg <= snd_eff;
                if (restart)
                begin
                    sample_index_reg <= '0;
                    phase_main_reg   <= '0;
                    phase_fifth_reg  <= '0;
                end
            end

            if (state_reg == S_DIV)
                cnt_reg <= cnt_reg + CW'(1);
            else
                cnt_reg <= '0;

            if ((state_reg == S_OUT) && can_write)
            begin
                out_valid_reg <= 1'b1;
                if (act_reg)
                begin
                    if (done_reg)
                        sounding_reg <= 1'b0;
                    else
                    begin
                        sample_index_reg <= sample_index_reg + LEN_W'(1);
                        phase_main_reg   <= phase_main_reg + PHASE_BITS'(tone_step_reg);
                        phase_fifth_reg  <= phase_fifth_reg + PHASE_BITS'(step_fifth);
                    end
                end
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];

        if (accept)
        begin
            act_reg  <= snd_eff;
            done_reg <= (i_eff == (note_length_reg - LEN_W'(1)));
            en_reg   <= en_new;
            dsh_reg  <= NUM_W'(den_new) << (Q_W - 1);
        end

        unique case (state_reg)
            S_IDX1, S_IDX2:
                prod_reg <= mul_p;
            S_ROM2:
                mix_reg <= (s_ext <<< 3) - s_ext;               // 7 * s1
            S_MIX:
                mix_reg <= mix_reg + (s_ext <<< 1) + s_ext;     // + 3 * s2
            S_MUL:
            begin
                prod_reg <= mul_p;
                neg_reg  <= mix_reg[MIX_W-1];
            end
            S_DIV:
            begin
                if (div_ge)
                    prod_reg <= PW'(div_rem);
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= {q_reg[Q_W-2:0], div_ge};
            end
            default:
                prod_reg <= prod_reg;
        endcase

        if ((state_reg == S_OUT) && can_write)
        begin
            if (act_reg)
                sample_reg <= neg_reg ? -q_signed : q_signed;
            else
                sample_reg <= '0;
            note_done_reg <= act_reg && done_reg;
            active_reg    <= act_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign note_done = note_done_reg;
    assign active    = active_reg;

endmodule
